// ===== design/gms_pkg.sv =====
// Shared types, microcode encodings and the exp table builder for the Metropolis step.
package gms_pkg;

    // Default configuration of the number formats
    localparam int FRAC_BITS_DEF      = 16;
    localparam int EXP_TABLE_BITS_DEF = 8;
    localparam int EXP_TBL_BITS_MAX   = 10;

    // log2(e) in Q30
    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

    // Configuration register indexes
    localparam logic CFG_TARGET_MEAN = 1'b0;
    localparam logic CFG_INV_TWO_VAR = 1'b1;

    // Transaction payloads
    typedef struct packed {
        logic signed [31:0] noise;
        logic [15:0]        uniform;
        logic               restart;
    } t_in;

    typedef struct packed {
        logic signed [31:0] sample;
        logic               accepted;
    } t_out;

    // Microcode program counter
    typedef logic [3:0] t_pc;

    localparam t_pc PC_DIFF = 4'd0;
    localparam t_pc PC_SQA  = 4'd1;
    localparam t_pc PC_SQB  = 4'd2;
    localparam t_pc PC_CMP  = 4'd3;
    localparam t_pc PC_MLO  = 4'd4;
    localparam t_pc PC_MHI  = 4'd5;
    localparam t_pc PC_YSAT = 4'd6;
    localparam t_pc PC_MZ   = 4'd7;
    localparam t_pc PC_EXP  = 4'd8;
    localparam t_pc PC_FIN  = 4'd9;

    // ALU operations
    localparam logic [2:0] ALU_NOP  = 3'd0;
    localparam logic [2:0] ALU_DIFF = 3'd1;
    localparam logic [2:0] ALU_CMP  = 3'd2;
    localparam logic [2:0] ALU_YSAT = 3'd3;
    localparam logic [2:0] ALU_EXP  = 3'd4;
    localparam logic [2:0] ALU_FIN  = 3'd5;

    // Multiplier operand selects
    localparam logic [2:0] MSEL_AA = 3'd0;
    localparam logic [2:0] MSEL_BB = 3'd1;
    localparam logic [2:0] MSEL_LO = 3'd2;
    localparam logic [2:0] MSEL_HI = 3'd3;
    localparam logic [2:0] MSEL_YL = 3'd4;

    // Product destination
    localparam logic MDST_PA = 1'b0;
    localparam logic MDST_PB = 1'b1;

    // Jump conditions
    localparam logic [1:0] COND_NONE    = 2'd0;
    localparam logic [1:0] COND_RESTART = 2'd1;
    localparam logic [1:0] COND_LE      = 2'd2;

    // One control word per program step
    typedef struct packed {
        logic [2:0] alu;
        logic       mul_en;
        logic [2:0] msel;
        logic       mdst;
        logic [1:0] cond;
        t_pc        target;
        logic       last;
    } t_ucw;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic restart;
        logic le;
    } t_dp_flags;

    // Bitwise integer square root, elaboration use only
    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'h1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // 2^(-idx/2^tbits) in Q16, built from repeated square roots of 1/2
    function automatic logic [16:0] exp_tbl_entry(input int idx, input int tbits);
        logic [63:0] c [0:EXP_TBL_BITS_MAX];
        logic [63:0] v;
        c[0] = 64'h1 << 30;
        c[1] = isqrt64(64'h1 << 59);
        for (int k = 1; k < EXP_TBL_BITS_MAX; k++) begin
            c[k + 1] = isqrt64(c[k] << 30);
        end
        v = 64'h1 << 30;
        for (int k = 1; k <= EXP_TBL_BITS_MAX; k++) begin
            if (k <= tbits) begin
                if (((idx >> (tbits - k)) & 1) != 0) begin
                    v = (v * c[k]) >> 30;
                end
            end
        end
        return 17'(v >> 14);
    endfunction

endpackage

// ===== design/gms_ucode_rom.sv =====
// Microcode program of the Metropolis step: one control word per step.
module gms_ucode_rom
    import gms_pkg::*;
(
    input  t_pc  i_pc,
    output t_ucw o_ucw
);

    function automatic t_ucw ucw(input logic [2:0] alu, input logic mul_en,
                                 input logic [2:0] msel, input logic mdst,
                                 input logic [1:0] cond, input t_pc target,
                                 input logic last);
        t_ucw w;
        w.alu    = alu;
        w.mul_en = mul_en;
        w.msel   = msel;
        w.mdst   = mdst;
        w.cond   = cond;
        w.target = target;
        w.last   = last;
        return w;
    endfunction

    // Program: differences, two squares, compare, 64x32 product in two halves,
    // saturate, scale by log2(e), table lookup, finish
    always_comb begin
        unique case (i_pc)
            PC_DIFF: o_ucw = ucw(ALU_DIFF, 1'b0, MSEL_AA, MDST_PA, COND_RESTART, PC_FIN, 1'b0);
            PC_SQA:  o_ucw = ucw(ALU_NOP,  1'b1, MSEL_AA, MDST_PA, COND_NONE,    PC_FIN, 1'b0);
            PC_SQB:  o_ucw = ucw(ALU_NOP,  1'b1, MSEL_BB, MDST_PB, COND_NONE,    PC_FIN, 1'b0);
            PC_CMP:  o_ucw = ucw(ALU_CMP,  1'b0, MSEL_AA, MDST_PA, COND_LE,      PC_FIN, 1'b0);
            PC_MLO:  o_ucw = ucw(ALU_NOP,  1'b1, MSEL_LO, MDST_PA, COND_NONE,    PC_FIN, 1'b0);
            PC_MHI:  o_ucw = ucw(ALU_NOP,  1'b1, MSEL_HI, MDST_PB, COND_NONE,    PC_FIN, 1'b0);
            PC_YSAT: o_ucw = ucw(ALU_YSAT, 1'b0, MSEL_AA, MDST_PA, COND_NONE,    PC_FIN, 1'b0);
            PC_MZ:   o_ucw = ucw(ALU_NOP,  1'b1, MSEL_YL, MDST_PA, COND_NONE,    PC_FIN, 1'b0);
            PC_EXP:  o_ucw = ucw(ALU_EXP,  1'b0, MSEL_AA, MDST_PA, COND_NONE,    PC_FIN, 1'b0);
            PC_FIN:  o_ucw = ucw(ALU_FIN,  1'b0, MSEL_AA, MDST_PA, COND_NONE,    PC_FIN, 1'b1);
            default: o_ucw = ucw(ALU_NOP,  1'b0, MSEL_AA, MDST_PA, COND_NONE,    PC_FIN, 1'b0);
        endcase
    end

endmodule

// ===== design/gms_datapath.sv =====
// Datapath of the Metropolis step: shared multiplier, ALU ops, exp table and chain state.
module gms_datapath
    import gms_pkg::*;
#(
    parameter int FRAC_BITS      = FRAC_BITS_DEF,
    parameter int EXP_TABLE_BITS = EXP_TABLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  t_in                i_item,
    input  logic               i_exec,
    input  t_ucw               i_ucw,
    input  logic signed [31:0] i_target_mean,
    input  logic [31:0]        i_inv_two_var,
    output t_dp_flags          o_flags,
    output t_out               o_result
);

    localparam int YW       = FRAC_BITS + 5;
    localparam int ZW       = FRAC_BITS + 6;
    localparam int FW       = FRAC_BITS + EXP_TABLE_BITS;
    localparam int TBL_SIZE = 1 << EXP_TABLE_BITS;
    localparam int UNI_LSH  = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int UNI_RSH  = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam int IDX_LSH  = (FRAC_BITS < EXP_TABLE_BITS) ? EXP_TABLE_BITS - FRAC_BITS : 0;
    localparam int IDX_RSH  = (FRAC_BITS >= EXP_TABLE_BITS) ? FRAC_BITS - EXP_TABLE_BITS : 0;
    localparam logic [YW-1:0] YCAP = YW'(24 << FRAC_BITS);

    // Magnitude of a 33-bit difference, capped at 32 bits
    function automatic logic [31:0] mag_cap(input logic [32:0] d);
        logic [32:0] m;
        m = d[32] ? (~d + 33'd1) : d;
        return m[32] ? 32'hFFFF_FFFF : m[31:0];
    endfunction

    t_in                r_item;
    logic signed [31:0] r_x;
    logic [31:0]        r_p;
    logic [31:0]        r_a;
    logic [31:0]        r_b;
    logic [63:0]        r_pa;
    logic [63:0]        r_pb;
    logic [63:0]        r_dq;
    logic [YW-1:0]      r_y;
    logic               r_take;

    logic [32:0]        sum33;
    logic [31:0]        p_sat;
    logic [32:0]        dp;
    logic [32:0]        dx;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [63:0]        mul_p;
    logic               le;
    logic               hi_sat;
    logic [64:0]        ysum;
    logic [64:0]        yfull;
    logic [YW-1:0]      y_next;
    logic [ZW-1:0]      z;
    logic [5:0]         z_int;
    logic [FW-1:0]      f_ext;
    logic [EXP_TABLE_BITS-1:0] idx;
    logic [16:0]        prob;
    logic               take_exp;
    logic [31:0]        uni_ext;
    logic [31:0]        uni_q;
    logic [16:0]        tbl [TBL_SIZE];

    // Constant table of 2^-frac in Q16
    for (genvar g = 0; g < TBL_SIZE; g++) begin : g_tbl
        localparam logic [16:0] ENTRY = exp_tbl_entry(g, EXP_TABLE_BITS);
        assign tbl[g] = ENTRY;
    end

    // Proposal with saturation, distances to the mean
    assign sum33 = {r_x[31], r_x} + {r_item.noise[31], r_item.noise};
    always_comb begin
        if (sum33[32] != sum33[31]) begin
            p_sat = sum33[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            p_sat = sum33[31:0];
        end
    end
    assign dp = {p_sat[31], p_sat} - {i_target_mean[31], i_target_mean};
    assign dx = {r_x[31], r_x} - {i_target_mean[31], i_target_mean};

    // Shared 32x32 multiplier operand select
    always_comb begin
        unique case (i_ucw.msel)
            MSEL_AA: begin
                mul_a = r_a;
                mul_b = r_a;
            end
            MSEL_BB: begin
                mul_a = r_b;
                mul_b = r_b;
            end
            MSEL_LO: begin
                mul_a = r_dq[31:0];
                mul_b = i_inv_two_var;
            end
            MSEL_HI: begin
                mul_a = r_dq[63:32];
                mul_b = i_inv_two_var;
            end
            MSEL_YL: begin
                mul_a = 32'(r_y);
                mul_b = 32'(LOG2E_Q30);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // Compare of squared distances
    assign le = (r_pa <= r_pb);

    // Scaled difference: hi half in r_pb, lo half in r_pa, saturate at 24
    assign hi_sat = |r_pb[63:31];
    assign ysum   = {2'b00, r_pb[30:0], 32'h0} + {1'b0, r_pa};
    assign yfull  = ysum >> FRAC_BITS;
    assign y_next = (hi_sat || ysum[64] || (yfull > 65'(YCAP))) ? YCAP : yfull[YW-1:0];

    // 2^-z: table on the fraction, shift by the integer part
    assign z        = r_pa[30 +: ZW];
    assign z_int    = z[FRAC_BITS +: 6];
    assign f_ext    = (FW'(z[FRAC_BITS-1:0]) << IDX_LSH) >> IDX_RSH;
    assign idx      = f_ext[EXP_TABLE_BITS-1:0];
    assign prob     = (z_int >= 6'd16) ? 17'd0 : (tbl[idx] >> z_int[3:0]);
    assign take_exp = ({1'b0, r_item.uniform} < prob);

    // Restart sample: uniform draw moved to the sample's fraction point
    assign uni_ext = 32'(r_item.uniform);
    assign uni_q   = (uni_ext << UNI_LSH) >> UNI_RSH;

    // Result of the finishing step
    always_comb begin
        o_result.accepted = r_item.restart | r_take;
        if (r_item.restart) begin
            o_result.sample = uni_q;
        end else if (r_take) begin
            o_result.sample = r_p;
        end else begin
            o_result.sample = r_x;
        end
    end

    assign o_flags.restart = r_item.restart;
    assign o_flags.le      = le;

    // Chain state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
        end else if (i_exec && (i_ucw.alu == ALU_FIN)) begin
            r_x <= o_result.sample;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
        if (i_exec) begin
            unique case (i_ucw.alu) inside
                ALU_DIFF: begin
                    r_p <= p_sat;
                    r_a <= mag_cap(dp);
                    r_b <= mag_cap(dx);
                end
                ALU_CMP: begin
                    r_take <= le;
                    r_dq   <= (r_pa - r_pb) >> FRAC_BITS;
                end
                ALU_YSAT: r_y <= y_next;
                ALU_EXP:  r_take <= take_exp;
                ALU_NOP, ALU_FIN: ;
                default: ;
            endcase
            if (i_ucw.mul_en) begin
                if (i_ucw.mdst == MDST_PB) begin
                    r_pb <= mul_p;
                end else begin
                    r_pa <= mul_p;
                end
            end
        end
    end

endmodule

// ===== design/gaussian_metropolis_step.sv =====
// Top level of the random-walk Metropolis step: sequencer, config registers, output register.
//
// One step of a random-walk Metropolis sampler for a Gaussian target in signed
// Q16.16: each transaction brings a noise sample and a 16-bit uniform draw and
// returns the new chain sample and whether the proposal was taken; a restart
// transaction loads the uniform draw as the first sample. The work runs as a
// ten-step microprogram over one shared 32x32 multiplier, so only one item is
// in flight at a time. A restart jumps from the difference step straight to the
// finish, a proposal no farther from the mean skips the exponential test, and
// otherwise every step runs; the multiplier (two squares, two halves of the
// scaled difference, the log2(e) scaling) serves those steps in turn. The result
// waits in an output register, and the next item is taken while it waits.
// Configuration writes are taken at any time but belong to idle periods.
module gaussian_metropolis_step
    import gms_pkg::*;
#(
    parameter int FRAC_BITS      = FRAC_BITS_DEF,
    parameter int EXP_TABLE_BITS = EXP_TABLE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in,
    // result item
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic               r_busy;
    t_pc                r_pc;
    logic               r_out_valid;
    t_out               r_out;
    logic signed [31:0] r_target_mean;
    logic [31:0]        r_inv_two_var;

    t_ucw      ucw;
    t_dp_flags flags;
    t_out      result;
    logic      in_acc;
    logic      exec;
    logic      fin_exec;
    logic      jump;

    gms_ucode_rom u_rom (
        .i_pc  (r_pc),
        .o_ucw (ucw)
    );

    gms_datapath #(
        .FRAC_BITS      (FRAC_BITS),
        .EXP_TABLE_BITS (EXP_TABLE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (in_acc),
        .i_item        (i_in),
        .i_exec        (exec),
        .i_ucw         (ucw),
        .i_target_mean (r_target_mean),
        .i_inv_two_var (r_inv_two_var),
        .o_flags       (flags),
        .o_result      (result)
    );

    // Handshake
    assign o_in_stall  = r_busy;
    assign in_acc      = i_in_valid && !r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    // Step executes unless the finishing step finds the output slot full
    assign exec     = r_busy && !(ucw.last && r_out_valid && i_out_stall);
    assign fin_exec = exec && ucw.last;

    // Conditional jump
    always_comb begin
        unique case (ucw.cond)
            COND_NONE:    jump = 1'b0;
            COND_RESTART: jump = flags.restart;
            COND_LE:      jump = flags.le;
            default:      jump = 1'b0;
        endcase
    end

    // Sequencer and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pc        <= PC_DIFF;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_busy <= 1'b1;
                r_pc   <= PC_DIFF;
            end else if (exec) begin
                if (ucw.last) begin
                    r_busy <= 1'b0;
                end else if (jump) begin
                    r_pc <= ucw.target;
                end else begin
                    r_pc <= r_pc + t_pc'(1);
                end
            end
            if (fin_exec) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (fin_exec) begin
            r_out <= result;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_mean <= '0;
            r_inv_two_var <= 32'd32768;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_TARGET_MEAN: r_target_mean <= i_cfg_data;
                CFG_INV_TWO_VAR: r_inv_two_var <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // An accepted transaction starts the program
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_busy && (r_pc == PC_DIFF)))
        else $error("accepted item did not start the program");

    // The program counter never leaves the program
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pc <= PC_FIN))
        else $error("program counter out of range");

    // A restart always reports a taken sample
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin_exec && flags.restart) |=> (r_out_valid && r_out.accepted))
        else $error("restart result not marked accepted");

endmodule

// ===== dv/gms_step_checker.sv =====
`timescale 1ns / 1ps
// Channel monitor, chain predictor and result comparison for the Metropolis step block.
module gms_step_checker
    import gms_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in         i_in,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out        i_out,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_mismatches,
    output int          o_outstanding
);

    localparam int          FRAC       = 16;
    localparam int          TABLE_BITS = 8;
    localparam logic [63:0] Y_CAP      = 64'd24 << FRAC;
    localparam logic [63:0] LOG2E      = 64'd1549082005;

    // 2^(-i/256) in Q16
    logic [16:0] pow2_frac [0:(1 << TABLE_BITS) - 1];

    // Predicted block state and configuration
    logic signed [31:0] chain_sample = '0;
    logic signed [31:0] target_mean  = '0;
    logic [31:0]        inv_two_var  = 32'd32768;

    t_out expected_draws [$];
    int   mismatch_count = 0;
    int   draw_count     = 0;

    assign o_mismatches = mismatch_count;

    // Floor square root, one result bit per pass from the top
    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) root = trial;
        end
        return root;
    endfunction

    // Build the exponent fraction table from chained square roots of one half
    initial begin : build_pow2_table
        logic [63:0] root [0:TABLE_BITS];
        logic [63:0] v;
        root[0] = 64'd1 << 30;
        root[1] = int_sqrt(64'd1 << 59);
        for (int k = 1; k < TABLE_BITS; k++) root[k + 1] = int_sqrt(root[k] << 30);
        for (int i = 0; i < (1 << TABLE_BITS); i++) begin
            v = 64'd1 << 30;
            for (int k = 1; k <= TABLE_BITS; k++) begin
                if (((i >> (TABLE_BITS - k)) & 1) != 0) v = (v * root[k]) >> 30;
            end
            pow2_frac[i] = 17'(v >> 14);
        end
    end

    // Square of a distance, magnitude capped to 32 bits
    function automatic logic [63:0] capped_square(input logic signed [33:0] d);
        logic [33:0] m;
        m = d[33] ? -d : d;
        if (m > 34'h0_FFFF_FFFF) m = 34'h0_FFFF_FFFF;
        return {32'b0, m[31:0]} * {32'b0, m[31:0]};
    endfunction

    // Advance the predicted chain by one transaction and return the expected result
    function automatic t_out next_draw(input t_in item);
        logic signed [31:0] x;
        logic signed [31:0] noise;
        logic signed [31:0] p;
        logic signed [33:0] psum;
        logic [63:0]        sq_p;
        logic [63:0]        sq_x;
        logic [63:0]        dq;
        logic [63:0]        hi;
        logic [63:0]        lo;
        logic [63:0]        t;
        logic [63:0]        y;
        logic [63:0]        z;
        logic [63:0]        s;
        logic [63:0]        prob;
        logic [7:0]         idx;
        logic               take;
        t_out               res;
        x = chain_sample;
        noise = item.noise;
        if (item.restart) begin
            // new chain starts at the uniform draw, noise unused
            chain_sample = {16'b0, item.uniform};
            take = 1'b1;
        end else begin
            psum = x + noise;
            if (psum[33:31] == 3'b000 || psum[33:31] == 3'b111) p = psum[31:0];
            else p = psum[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            sq_p = capped_square(p - target_mean);
            sq_x = capped_square(x - target_mean);
            if (sq_p <= sq_x) begin
                take = 1'b1;
            end else begin
                // scaled log-ratio, saturating, then 2^-z by table and shift
                dq = (sq_p - sq_x) >> FRAC;
                hi = (dq >> 32) * {32'b0, inv_two_var};
                lo = {32'b0, dq[31:0]} * {32'b0, inv_two_var};
                if (hi[63:31] != '0) begin
                    y = Y_CAP;
                end else begin
                    t = hi << 32;
                    if (t > ~lo) begin
                        y = Y_CAP;
                    end else begin
                        y = (t + lo) >> FRAC;
                        if (y > Y_CAP) y = Y_CAP;
                    end
                end
                z = (y * LOG2E) >> 30;
                s = z >> FRAC;
                idx = z[FRAC-1 -: TABLE_BITS];
                prob = (s >= 64'd16) ? 64'd0 : ({47'b0, pow2_frac[idx]} >> s);
                take = {48'b0, item.uniform} < prob;
            end
            if (take) chain_sample = p;
        end
        res.sample = chain_sample;
        res.accepted = take;
        return res;
    endfunction

    task automatic log_failure(input string msg);
        if (mismatch_count < 10) $display("%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // Watch the three channels on every edge
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            chain_sample = '0;
            target_mean = '0;
            inv_two_var = 32'd32768;
            expected_draws.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_TARGET_MEAN) target_mean = i_cfg_data;
                else inv_two_var = i_cfg_data;
            end
            // results first, so a same-edge input is not paired with its own result
            if (i_out_valid && !i_out_stall) begin
                if (expected_draws.size() == 0) begin
                    log_failure($sformatf("unexpected result: sample %h accepted %b",
                                          i_out.sample, i_out.accepted));
                end else begin
                    want = expected_draws.pop_front();
                    if (i_out.sample !== want.sample || i_out.accepted !== want.accepted)
                        log_failure($sformatf(
                            "draw %0d: expected sample %h accepted %b, got sample %h accepted %b",
                            draw_count, want.sample, want.accepted,
                            i_out.sample, i_out.accepted));
                end
                draw_count++;
            end
            if (i_in_valid && !i_in_stall) expected_draws.push_back(next_draw(i_in));
        end
        o_outstanding <= expected_draws.size();
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Testbench top: clock, reset, stimulus, receiver stalls, watchdog and verdict.
module tb;
    import gms_pkg::*;

    localparam int HALF_PERIOD     = 4;
    localparam int RESET_CYCLES    = 12;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int HOLD_CYCLES     = 400;
    localparam int QUIET_LIMIT     = 4000;
    localparam int DRAIN_CYCLES    = 16;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    t_in         in_item   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out        out_item;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_TARGET_MEAN;
    logic [31:0] cfg_data  = '0;

    int   mismatches;
    int   outstanding;
    int   burst_left  = 0;
    int   quiet_cycles = 0;
    logic hold_wanted = 1'b0;

    always #(HALF_PERIOD) clk = ~clk;

    gaussian_metropolis_step dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    gms_step_checker draw_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in          (in_item),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out         (out_item),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // Offer one transaction; the sender runs in bursts with random gaps between them
    task automatic push_item(input logic signed [31:0] noise_v, input logic [15:0] uniform_v,
                             input logic restart_v);
        t_in item;
        int  gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
            gap = $urandom_range(0, 10);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        item.noise = noise_v;
        item.uniform = uniform_v;
        item.restart = restart_v;
        in_valid <= 1'b1;
        in_item <= item;
        do @(posedge clk); while (in_stall);
        burst_left--;
    endtask

    // Mostly small random-walk steps with occasional restarts, some wide noise
    task automatic random_item();
        logic signed [31:0] step;
        int                 pick;
        pick = $urandom_range(99);
        if (pick < 75) step = int'($urandom_range(0, 1 << 19)) - (1 << 18);
        else if (pick < 90) step = int'($urandom_range(0, 1 << 25)) - (1 << 24);
        else step = $urandom;
        push_item(step, 16'($urandom_range(0, 65535)), $urandom_range(99) < 5);
    endtask

    // Let the block drain completely
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write both registers back to back; valid stays high across the pair
    task automatic load_config(input logic [31:0] mean, input logic [31:0] itv);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_TARGET_MEAN;
        cfg_data <= mean;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_INV_TWO_VAR;
        cfg_data <= itv;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Receiver: stall segments of varying density, plus one long hold-off on request
    initial begin : receiver
        int seg_len;
        int pct;
        wait (rst_n);
        forever begin
            if (hold_wanted) begin
                @(posedge clk);
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_wanted = 1'b0;
            end
            seg_len = $urandom_range(10, 150);
            case ($urandom_range(4))
                0, 1: pct = 0;
                2: pct = 25;
                3: pct = 50;
                default: pct = 85;
            endcase
            repeat (seg_len) begin
                @(posedge clk);
                out_stall <= ($urandom_range(99) < pct);
            end
        end
    end

    // Watchdog: too long without any transaction on any channel
    always @(posedge clk) begin
        if (rst_n && !(in_valid && !in_stall) && !(out_valid && !out_stall)
            && !(cfg_valid && cfg_ready)) begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end else begin
            quiet_cycles = 0;
        end
    end

    initial begin : stimulus
        logic [31:0] mean;
        logic [31:0] itv;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: default configuration
        load_config(32'd0, 32'd32768);
        push_item(32'sh8000_0000, 16'h0000, 1'b1);  // restart at zero, noise ignored
        push_item(32'sh0000_0000, 16'hFFFF, 1'b0);  // zero step, equal distance
        push_item(32'sh7FFF_FFFF, 16'hFFFF, 1'b1);  // restart at the largest draw
        push_item(-32'sh0000_8000, 16'hFFFF, 1'b0); // toward the mean
        push_item(32'sh0001_0000, 16'h0000, 1'b0);  // away, lowest draw takes it
        push_item(32'sh0001_0000, 16'hFFFF, 1'b0);  // away, highest draw refuses
        push_item(32'sh7FFF_FFFF, 16'h0000, 1'b0);  // proposal clips high, zero probability
        push_item(32'sh8000_0000, 16'h0000, 1'b0);  // far below
        push_item(32'shAAAA_5555, 16'h8000, 1'b1);
        push_item(32'sh5555_AAAA, 16'h5555, 1'b0);
        settle();

        // Directed: zero inverse variance takes everything, exercise clipping
        load_config(32'd0, 32'd0);
        push_item(32'sh7FFF_FFFF, 16'hFFFF, 1'b0);
        push_item(32'sh7FFF_FFFF, 16'hFFFF, 1'b0);
        push_item(32'sh8000_0000, 16'hAAAA, 1'b0);
        push_item(32'sh8000_0000, 16'hFFFF, 1'b0);
        push_item(32'sh8000_0000, 16'hFFFF, 1'b0);
        settle();

        // Directed: extreme mean and scale
        load_config(32'h7FFF_FFFF, 32'hFFFF_FFFF);
        push_item(32'sh0000_0000, 16'h1234, 1'b1);
        push_item(32'sh0000_0100, 16'hFFFF, 1'b0);
        push_item(-32'sh0000_0010, 16'h0000, 1'b0);
        push_item(32'sh0000_0000, 16'h0000, 1'b0);
        settle();

        load_config(32'h8000_0000, 32'd1);
        push_item(-32'sh0000_0100, 16'hFFFF, 1'b0);
        push_item(32'sh0001_0000, 16'h0000, 1'b0);
        push_item(32'sh0001_0000, 16'hFFFF, 1'b0);
        settle();

        // Random phases, each under its own setting
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: begin
                    mean = int'($urandom_range(0, 1 << 19)) - (1 << 18);
                    itv = 32'd32768;
                end
                1: begin
                    mean = '0;
                    itv = '0;
                end
                2: begin
                    mean = 32'h7FFF_FFFF;
                    itv = 32'hFFFF_FFFF;
                end
                3: begin
                    mean = 32'h8000_0000;
                    itv = $urandom_range(1 << 10, 1 << 20);
                end
                default: begin
                    mean = ($urandom_range(3) == 0) ? $urandom
                         : int'($urandom_range(0, 1 << 19)) - (1 << 18);
                    itv = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1 << 10, 1 << 20);
                end
            endcase
            load_config(mean, itv);
            if (ph == 4) hold_wanted = 1'b1;
            repeat (ITEMS_PER_PHASE) random_item();
            settle();
        end

        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/gms_pkg.sv
design/gms_ucode_rom.sv
design/gms_datapath.sv
design/gaussian_metropolis_step.sv
dv/gms_step_checker.sv
dv/tb.sv
